@@ rtl/ecmd_pkg.sv @@
// Shared types and constants for the encoder counter display block.
// Used by ecmd_digit and encoder_counter_mux_display; no dependencies.
package ecmd_pkg;

    localparam int CountW = 12;
    localparam int LoadW  = 16;
    localparam int SegW   = 7;
    localparam int DigW   = 4;
    localparam int PosW   = 2;

    // command codes
    localparam logic [1:0] CMD_REFRESH = 2'd0;
    localparam logic [1:0] CMD_ENCODER = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef struct packed {
        logic [1:0]       cmd;
        logic             encoder_dir;
        logic [LoadW-1:0] load_value;
    } req_word_t;

    typedef struct packed {
        logic [SegW-1:0]   segments_n;
        logic [DigW-1:0]   digit_enable_n;
        logic [CountW-1:0] count;
        logic              load_rejected;
    } rsp_word_t;

    // display drive for one refresh
    typedef struct packed {
        logic [SegW-1:0] seg_n;
        logic [DigW-1:0] dig_n;
    } disp_t;

endpackage

@@ rtl/ecmd_digit.sv @@
// Decimal digit pick and seven-segment encode for one display position.
// Depends on ecmd_pkg.
module ecmd_digit
    import ecmd_pkg::*;
(
    input  logic [CountW-1:0] value,
    input  logic [PosW-1:0]   pos,
    output disp_t             disp
);

    logic [2:0]  th;
    logic [3:0]  hu;
    logic [3:0]  te;
    logic [3:0]  un;
    logic [9:0]  rem_th;
    logic [6:0]  rem_hu;
    logic [3:0]  digit;

    // thousands: parallel compares against multiples of 1000
    always_comb
    begin
        th = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            if (value >= 12'(k * 1000))
                th = 3'(k);
        end
        rem_th = 10'(value - 12'(th) * 12'd1000);
    end

    always_comb
    begin
        hu = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_th >= 10'(k * 100))
                hu = 4'(k);
        end
        rem_hu = 7'(rem_th - 10'(hu) * 10'd100);
    end

    always_comb
    begin
        te = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_hu >= 7'(k * 10))
                te = 4'(k);
        end
        un = 4'(rem_hu - 7'(te) * 7'd10);
    end

    always_comb
    begin
        case (pos)
            2'd0:    digit = un;
            2'd1:    digit = te;
            2'd2:    digit = hu;
            default: digit = {1'b0, th};
        endcase
    end

    // active-low patterns, bit0 = a .. bit6 = g
    always_comb
    begin
        case (digit)
            4'd0:    disp.seg_n = 7'h40;
            4'd1:    disp.seg_n = 7'h79;
            4'd2:    disp.seg_n = 7'h24;
            4'd3:    disp.seg_n = 7'h30;
            4'd4:    disp.seg_n = 7'h19;
            4'd5:    disp.seg_n = 7'h12;
            4'd6:    disp.seg_n = 7'h02;
            4'd7:    disp.seg_n = 7'h78;
            4'd8:    disp.seg_n = 7'h00;
            default: disp.seg_n = 7'h10;
        endcase
        disp.dig_n = ~(DigW'(1) << pos);
    end

endmodule

@@ rtl/encoder_counter_mux_display.sv @@
// Top level: encoder-stepped 12-bit counter driving a 4-digit muxed display.
// Depends on ecmd_pkg and ecmd_digit.
//
// Usage:
//   req channel (req_valid/req_stall/req_word) takes one command word per
//   accepted edge: refresh tick, encoder edge or counter load.
//   rsp channel (rsp_valid/rsp_stall/rsp_word) returns exactly one word per
//   command, in order: held segment and digit drive, counter value after
//   the command, and a flag for a load above 4095.
// Path: an accepted command passes the input register, then the result
//   buffer, before its response is valid. Throughput: one word per cycle
//   while req_stall is low, set by the single-pass update of the counter
//   and display state between the input register and the result buffer.
// Stall: the result buffer holds three words; req_stall rises only when
//   the input register and the buffer together hold three words, so the
//   block keeps accepting while one result waits on rsp_stall.
// Reset (rst_n low, async): counter 0, display position on units, all
//   segments and digits dark, buffers empty.
module encoder_counter_mux_display
    import ecmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    localparam int Depth = 3;

    // input register
    logic       s1_vld_reg;
    req_word_t  s1_word_reg;

    // block state
    logic [CountW-1:0] counter_reg, counter_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [SegW-1:0]   seg_reg, seg_next;
    logic [DigW-1:0]   dig_reg, dig_next;
    logic              rejected;

    // result buffer
    rsp_word_t  fifo_reg [Depth];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic [2:0] pending;

    disp_t      disp;
    rsp_word_t  result;

    logic       req_accept;

    assign pending    = {2'b0, s1_vld_reg} + {1'b0, cnt_reg};
    assign req_stall  = (pending >= 3'(Depth));
    assign req_accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= req_accept;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            s1_word_reg <= req_word;
    end

    // digit of the stored counter at the current position
    ecmd_digit u_digit (
        .value (counter_reg),
        .pos   (pos_reg),
        .disp  (disp)
    );

    always_comb
    begin
        counter_next = counter_reg;
        pos_next     = pos_reg;
        seg_next     = seg_reg;
        dig_next     = dig_reg;
        rejected     = 1'b0;
        case (s1_word_reg.cmd)
            CMD_REFRESH:
            begin
                seg_next = disp.seg_n;
                dig_next = disp.dig_n;
                pos_next = pos_reg + PosW'(1);
            end
            CMD_ENCODER:
            begin
                if (s1_word_reg.encoder_dir)
                    counter_next = counter_reg + CountW'(1);
                else
                    counter_next = counter_reg - CountW'(1);
            end
            CMD_LOAD:
            begin
                // values above the counter range are refused
                if (s1_word_reg.load_value <= LoadW'(COUNT_MAX))
                    counter_next = CountW'(s1_word_reg.load_value);
                else
                    rejected = 1'b1;
            end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            pos_reg     <= '0;
            seg_reg     <= '1;
            dig_reg     <= '1;
        end
        else if (s1_vld_reg)
        begin
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            seg_reg     <= seg_next;
            dig_reg     <= dig_next;
        end
    end

    always_comb
    begin
        result.segments_n     = seg_next;
        result.digit_enable_n = dig_next;
        result.count          = counter_next;
        result.load_rejected  = rejected;
    end

    // result buffer: room is reserved at accept time, so a push never fails
    assign push      = s1_vld_reg;
    assign rsp_valid = (cnt_reg != 2'd0);
    assign pop       = rsp_valid && !rsp_stall;
    assign rsp_word  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == 2'(Depth - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == 2'(Depth - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= result;
    end

endmodule
